@@ rtl/mig_pkg.sv @@
package mig_pkg;

  // q16.16 word
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int CFG_W  = 4;

  typedef logic signed [DATA_W-1:0] q_t;

  localparam q_t Q_ONE = 32'sh0001_0000;
  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  // quotient bits produced by the divider: dividend is scaled by 2^16
  localparam int DIV_STEPS = DATA_W + FRAC_W;

  // divider request and response
  typedef struct packed {
    logic start;
    q_t   num;
    q_t   den;
  } div_req_t;

  typedef struct packed {
    logic done;
    q_t   quot;
  } div_rsp_t;

  // operands of the multiply-subtract unit
  typedef struct packed {
    q_t tgt;
    q_t src;
    q_t amt;
  } msub_op_t;

endpackage

@@ rtl/matrix_inverse_gauss_jordan.sv @@
// Inverts a square matrix of signed q16.16 entries by gauss-jordan elimination without
// pivoting. Set cfg_matrix_size (1..MAX_DIM, 0 acts as 1, larger acts as MAX_DIM), then load
// the matrix row-major, one entry per transaction, with in_last_in on the final one; while it
// loads, the block takes one entry per cycle. After the last entry the block stalls its input
// while it works, then returns the inverse row-major with out_last_out on the final entry,
// reading each entry from the result memory before it offers it. The work is done by one
// shared 48-step restoring divider (2n divides per column with a nonzero pivot) and one
// multiply-subtract unit. A zero pivot leaves its row unscaled; quotients and products
// truncate toward zero and saturate at the q16.16 limits.
module matrix_inverse_gauss_jordan
  import mig_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_matrix_size,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [31:0] in_element,
  input  logic              in_last_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [31:0] out_inverse_element,
  output logic              out_last_out
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(MAX_DIM);
  localparam int NW    = $clog2(MAX_DIM + 1);

  typedef enum logic [16:0] {
    S_LOAD = 17'h00001,
    S_INIT = 17'h00002,
    S_PRD  = 17'h00004,
    S_PCHK = 17'h00008,
    S_NRD  = 17'h00010,
    S_NST  = 17'h00020,
    S_NDIV = 17'h00040,
    S_ARD  = 17'h00080,
    S_ACHK = 17'h00100,
    S_BRD  = 17'h00200,
    S_BCHK = 17'h00400,
    S_MRD  = 17'h00800,
    S_MUL  = 17'h01000,
    S_SCL  = 17'h02000,
    S_WR   = 17'h04000,
    S_ORD  = 17'h08000,
    S_OUT  = 17'h10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  size_r;
  logic [NW-1:0]     n_live, n_r, n_nxt;
  logic [LW-1:0]     total_live, total_n;
  logic [LW-1:0]     ld_cnt_r, ld_cnt_nxt;
  logic [LW-1:0]     o_cnt_r, o_cnt_nxt;
  logic [IW-1:0]     i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic              sel_r, sel_nxt;
  logic              back_r, back_nxt;
  q_t                piv_r, piv_nxt;
  q_t                amt_r, amt_nxt;
  logic [IW-1:0]     last_ix;

  logic [IW-1:0]     row_a, col_a;
  logic [AW-1:0]     addr_a, addr_b;

  q_t                work_mem [DEPTH];
  q_t                res_mem  [DEPTH];
  q_t                m_rd_a_r, m_rd_b_r, r_rd_a_r, r_rd_b_r;

  logic              wm_en, wr_en;
  logic [AW-1:0]     wm_addr, wr_addr;
  q_t                wm_data, wr_data;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  msub_op_t          ms_op;
  q_t                ms_diff;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= CFG_W'(8);
    end else if (cfg_wr_en) begin
      size_r <= cfg_matrix_size;
    end
  end

  // size in use, clamped to 1..MAX_DIM
  always_comb begin
    if (size_r == '0) begin
      n_live = NW'(1);
    end else if (size_r > CFG_W'(MAX_DIM)) begin
      n_live = NW'(MAX_DIM);
    end else begin
      n_live = NW'(size_r);
    end
  end

  assign total_live = LW'(n_live) * LW'(n_live);
  assign total_n    = LW'(n_r) * LW'(n_r);
  assign last_ix    = IW'(n_r - 1'b1);

  // row and column of the target entry
  always_comb begin
    row_a = i_r;
    col_a = k_r;
    if (state_r == S_PRD || state_r == S_PCHK) begin
      row_a = j_r;
      col_a = j_r;
    end else if (state_r == S_ARD || state_r == S_ACHK ||
                 state_r == S_BRD || state_r == S_BCHK) begin
      col_a = j_r;
    end else if (state_r == S_NRD || state_r == S_NST || state_r == S_NDIV) begin
      row_a = j_r;
    end
  end

  assign addr_a = (state_r == S_ORD || state_r == S_OUT) ? o_cnt_r[AW-1:0]
                : AW'(AW'(row_a) * AW'(n_r) + AW'(col_a));
  assign addr_b = AW'(AW'(j_r) * AW'(n_r) + AW'(k_r));

  // matrix memories, registered reads at two addresses
  always_ff @(posedge clk) begin
    if (wm_en) begin
      work_mem[wm_addr] <= wm_data;
    end
    m_rd_a_r <= work_mem[addr_a];
    m_rd_b_r <= work_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      res_mem[wr_addr] <= wr_data;
    end
    r_rd_a_r <= res_mem[addr_a];
    r_rd_b_r <= res_mem[addr_b];
  end

  // shared arithmetic units
  assign div_req.start = (state_r == S_NST);
  assign div_req.num   = sel_r ? r_rd_a_r : m_rd_a_r;
  assign div_req.den   = piv_r;

  mig_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign ms_op.tgt = sel_r ? r_rd_a_r : m_rd_a_r;
  assign ms_op.src = sel_r ? r_rd_b_r : m_rd_b_r;
  assign ms_op.amt = amt_r;

  mig_msub u_msub (
    .clk  (clk),
    .op   (ms_op),
    .diff (ms_diff)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    ld_cnt_nxt = ld_cnt_r;
    o_cnt_nxt  = o_cnt_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    sel_nxt    = sel_r;
    back_nxt   = back_r;
    piv_nxt    = piv_r;
    amt_nxt    = amt_r;
    wm_en      = 1'b0;
    wm_addr    = addr_a;
    wm_data    = ms_diff;
    wr_en      = 1'b0;
    wr_addr    = addr_a;
    wr_data    = ms_diff;
    in_stall   = 1'b1;
    out_valid  = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (ld_cnt_r < total_live) begin
            wm_en      = 1'b1;
            wm_addr    = ld_cnt_r[AW-1:0];
            wm_data    = in_element;
            ld_cnt_nxt = ld_cnt_r + 1'b1;
          end
          if (in_last_in) begin
            n_nxt      = n_live;
            ld_cnt_nxt = '0;
            i_nxt      = '0;
            k_nxt      = '0;
            back_nxt   = 1'b0;
            sel_nxt    = 1'b0;
            state_nxt  = S_INIT;
          end
        end
      end

      // identity into the result matrix
      S_INIT: begin
        wr_en   = 1'b1;
        wr_data = (i_r == k_r) ? Q_ONE : '0;
        if (k_r == last_ix) begin
          k_nxt = '0;
          if (i_r == last_ix) begin
            j_nxt     = '0;
            state_nxt = S_PRD;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      S_PRD: state_nxt = S_PCHK;

      S_PCHK: begin
        piv_nxt = m_rd_a_r;
        k_nxt   = '0;
        sel_nxt = 1'b0;
        if (m_rd_a_r != '0) begin
          state_nxt = S_NRD;
        end else if (j_r == last_ix) begin
          if (n_r == NW'(1)) begin
            o_cnt_nxt = '0;
            state_nxt = S_ORD;
          end else begin
            j_nxt     = last_ix;
            i_nxt     = IW'(last_ix - 1'b1);
            back_nxt  = 1'b1;
            state_nxt = S_BRD;
          end
        end else begin
          i_nxt     = j_r + 1'b1;
          state_nxt = S_ARD;
        end
      end

      S_NRD: state_nxt = S_NST;
      S_NST: state_nxt = S_NDIV;

      // pivot row scaling, work entry then result entry
      S_NDIV: begin
        if (div_rsp.done) begin
          wm_en   = !sel_r;
          wr_en   = sel_r;
          wm_data = div_rsp.quot;
          wr_data = div_rsp.quot;
          if (!sel_r) begin
            sel_nxt   = 1'b1;
            state_nxt = S_NRD;
          end else begin
            sel_nxt = 1'b0;
            if (k_r != last_ix) begin
              k_nxt     = k_r + 1'b1;
              state_nxt = S_NRD;
            end else if (j_r == last_ix) begin
              if (n_r == NW'(1)) begin
                o_cnt_nxt = '0;
                state_nxt = S_ORD;
              end else begin
                j_nxt     = last_ix;
                i_nxt     = IW'(last_ix - 1'b1);
                back_nxt  = 1'b1;
                state_nxt = S_BRD;
              end
            end else begin
              i_nxt     = j_r + 1'b1;
              state_nxt = S_ARD;
            end
          end
        end
      end

      S_ARD: state_nxt = S_ACHK;

      S_ACHK: begin
        amt_nxt = m_rd_a_r;
        k_nxt   = '0;
        sel_nxt = 1'b0;
        if (m_rd_a_r != '0) begin
          state_nxt = S_MRD;
        end else if (i_r == last_ix) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_PRD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_ARD;
        end
      end

      S_BRD: state_nxt = S_BCHK;

      S_BCHK: begin
        amt_nxt   = m_rd_a_r;
        k_nxt     = '0;
        sel_nxt   = 1'b1;
        state_nxt = S_MRD;
      end

      S_MRD: state_nxt = S_MUL;
      S_MUL: state_nxt = S_SCL;
      S_SCL: state_nxt = S_WR;

      // write back one updated entry and step on
      S_WR: begin
        wm_en = !sel_r;
        wr_en = sel_r;
        if (!back_r) begin
          if (!sel_r) begin
            sel_nxt   = 1'b1;
            state_nxt = S_MRD;
          end else begin
            sel_nxt = 1'b0;
            if (k_r != last_ix) begin
              k_nxt     = k_r + 1'b1;
              state_nxt = S_MRD;
            end else if (i_r == last_ix) begin
              j_nxt     = j_r + 1'b1;
              state_nxt = S_PRD;
            end else begin
              i_nxt     = i_r + 1'b1;
              state_nxt = S_ARD;
            end
          end
        end else begin
          if (k_r != last_ix) begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_MRD;
          end else if (i_r != '0) begin
            i_nxt     = i_r - 1'b1;
            state_nxt = S_BRD;
          end else if (j_r == IW'(1)) begin
            o_cnt_nxt = '0;
            state_nxt = S_ORD;
          end else begin
            j_nxt     = j_r - 1'b1;
            i_nxt     = IW'(j_r - 2'd2);
            state_nxt = S_BRD;
          end
        end
      end

      S_ORD: state_nxt = S_OUT;

      // one inverse entry per transaction
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (o_cnt_r == total_n - 1'b1) begin
            state_nxt = S_LOAD;
          end else begin
            o_cnt_nxt = o_cnt_r + 1'b1;
            state_nxt = S_ORD;
          end
        end
      end

      default: state_nxt = S_LOAD;
    endcase
  end

  assign out_inverse_element = r_rd_a_r;
  assign out_last_out        = (o_cnt_r == total_n - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      n_r      <= NW'(MAX_DIM);
      ld_cnt_r <= '0;
      o_cnt_r  <= '0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      sel_r    <= 1'b0;
      back_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      n_r      <= n_nxt;
      ld_cnt_r <= ld_cnt_nxt;
      o_cnt_r  <= o_cnt_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      k_r      <= k_nxt;
      sel_r    <= sel_nxt;
      back_r   <= back_nxt;
    end
  end

  always_ff @(posedge clk) begin
    piv_r <= piv_nxt;
    amt_r <= amt_nxt;
  end

endmodule

@@ rtl/mig_div.sv @@
module mig_div
  import mig_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DIV_STEPS);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [DIV_STEPS-1:0] dvd_r, dvd_nxt;
  logic [DIV_STEPS-1:0] q_r, q_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    den_r, den_nxt;
  logic                 neg_r, neg_nxt;
  q_t                   quot_r, quot_nxt;

  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      rem_dif;
  logic                 ge;
  logic [DATA_W-1:0]    num_mag;
  logic [DATA_W-1:0]    den_mag;
  logic [DIV_STEPS-1:0] q_step;

  // magnitudes of the operands
  assign num_mag = req.num[DATA_W-1] ? DATA_W'(-req.num) : DATA_W'(req.num);
  assign den_mag = req.den[DATA_W-1] ? DATA_W'(-req.den) : DATA_W'(req.den);

  // one restoring step
  assign rem_sh  = {rem_r, dvd_r[DIV_STEPS-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_dif = rem_sh - {1'b0, den_r};
  assign q_step  = {q_r[DIV_STEPS-2:0], ge};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = {num_mag, {FRAC_W{1'b0}}};
      q_nxt    = '0;
      rem_nxt  = '0;
      den_nxt  = den_mag;
      neg_nxt  = req.num[DATA_W-1] ^ req.den[DATA_W-1];
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DIV_STEPS-2:0], 1'b0};
      q_nxt   = q_step;
      rem_nxt = ge ? rem_dif[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        // saturate at the q16.16 limits
        if (!neg_r) begin
          quot_nxt = (q_step > DIV_STEPS'(Q_MAX)) ? Q_MAX : q_t'(q_step[DATA_W-1:0]);
        end else begin
          quot_nxt = (q_step > {{(DIV_STEPS-DATA_W){1'b0}}, Q_MIN}) ? Q_MIN
                   : q_t'(-q_step[DATA_W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

@@ rtl/mig_msub.sv @@
module mig_msub
  import mig_pkg::*;
(
  input  logic     clk,
  input  msub_op_t op,
  output q_t       diff
);

  logic signed [2*DATA_W-1:0] prod_r;
  logic signed [2*DATA_W-1:0] adj;
  logic signed [2*DATA_W-1:0] shr;
  q_t                         mq_r, mq_nxt;
  logic signed [DATA_W:0]     dif;

  // stage one: full product
  always_ff @(posedge clk) begin
    prod_r <= op.src * op.amt;
  end

  // stage two: scale by 2^-16 toward zero, saturate
  assign adj = prod_r + (prod_r[2*DATA_W-1] ? (2*DATA_W)'((1 << FRAC_W) - 1) : '0);
  assign shr = adj >>> FRAC_W;

  always_comb begin
    if (shr > (2*DATA_W)'(Q_MAX)) begin
      mq_nxt = Q_MAX;
    end else if (shr < $signed({{DATA_W{1'b1}}, Q_MIN})) begin
      mq_nxt = Q_MIN;
    end else begin
      mq_nxt = q_t'(shr[DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    mq_r <= mq_nxt;
  end

  // saturating subtract
  assign dif = {op.tgt[DATA_W-1], op.tgt} - {mq_r[DATA_W-1], mq_r};

  always_comb begin
    if (dif[DATA_W] != dif[DATA_W-1]) begin
      diff = dif[DATA_W] ? Q_MIN : Q_MAX;
    end else begin
      diff = q_t'(dif[DATA_W-1:0]);
    end
  end

endmodule

@@ rtl/mig_checker.sv @@
module mig_checker
  import mig_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_last_in,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_inverse_element,
  input logic               out_last_out
);

  // a stalled result transaction holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inverse_element)
                               && $stable(out_last_out))
    else $error("stalled result changed");

  // no input transaction while results are offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during result delivery");

  // entries before the last keep the block loading
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last_in |=> !in_stall && !out_valid)
    else $error("load left without final entry");

  // reset leaves no result pending
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind matrix_inverse_gauss_jordan mig_checker u_mig_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_last_in          (in_last_in),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_inverse_element (out_inverse_element),
  .out_last_out        (out_last_out)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import mig_pkg::*;

  localparam int MAX_DIM = 8;

  // ---------------------------------------------------------------------------
  // inverse predictor and store of expected inverse entries
  // ---------------------------------------------------------------------------
  class inverse_scoreboard;
    q_t          loaded[MAX_DIM*MAX_DIM];
    int unsigned fill_count;
    logic [3:0]  size_reg;
    q_t          expected_entries[$];
    bit          expected_lasts[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned inversions;

    function new();
      foreach (loaded[i]) loaded[i] = '0;
      fill_count = 0;
      size_reg   = 4'd8;
      errors     = 0;
      checked    = 0;
      inversions = 0;
    endfunction

    function void set_size(logic [3:0] v);
      size_reg = v;
    endfunction

    function int unsigned dim();
      if (size_reg < 1) return 1;
      if (size_reg > MAX_DIM) return MAX_DIM;
      return size_reg;
    endfunction

    function q_t clamp(longint v);
      if (v > longint'(Q_MAX)) return Q_MAX;
      if (v < longint'(Q_MIN)) return Q_MIN;
      return q_t'(v);
    endfunction

    // q16.16 product, truncated toward zero
    function q_t fx_mul(q_t a, q_t b);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp(p / 65536);
    endfunction

    function q_t fx_div(q_t a, q_t b);
      if (b == 0) return a;
      return clamp((longint'(a) * 65536) / longint'(b));
    endfunction

    function q_t fx_sub(q_t a, q_t b);
      return clamp(longint'(a) - longint'(b));
    endfunction

    // gauss-jordan without pivoting, back substitution on result only
    function void invert(int unsigned n);
      q_t res[MAX_DIM*MAX_DIM];
      q_t piv;
      q_t amt;
      int j;
      int i;
      foreach (res[x]) res[x] = '0;
      for (i = 0; i < n; i++) res[i*n+i] = Q_ONE;
      for (j = 0; j < n; j++) begin
        piv = loaded[j*n+j];
        if (piv != 0) begin
          for (int k = 0; k < n; k++) begin
            loaded[j*n+k] = fx_div(loaded[j*n+k], piv);
            res[j*n+k]    = fx_div(res[j*n+k], piv);
          end
        end
        for (i = j + 1; i < n; i++) begin
          amt = loaded[i*n+j];
          if (amt != 0) begin
            for (int k = 0; k < n; k++) begin
              loaded[i*n+k] = fx_sub(loaded[i*n+k], fx_mul(loaded[j*n+k], amt));
              res[i*n+k]    = fx_sub(res[i*n+k], fx_mul(res[j*n+k], amt));
            end
          end
        end
      end
      for (j = n - 1; j > 0; j--) begin
        for (i = j; i > 0; i--) begin
          amt = loaded[(i-1)*n+j];
          for (int k = 0; k < n; k++)
            res[(i-1)*n+k] = fx_sub(res[(i-1)*n+k], fx_mul(res[j*n+k], amt));
        end
      end
      for (int k = 0; k < n*n; k++) begin
        expected_entries.push_back(res[k]);
        expected_lasts.push_back(k == n*n - 1);
      end
    endfunction

    // note an accepted input transaction
    function void note_input(q_t element, bit last);
      int unsigned n;
      n = dim();
      if (fill_count < n*n) begin
        loaded[fill_count] = element;
        fill_count++;
      end
      if (last) begin
        invert(n);
        fill_count = 0;
        inversions++;
      end
    endfunction

    // compare one accepted result transaction
    function void check_result(q_t got, bit got_last);
      q_t want;
      bit want_last;
      if (expected_entries.size() == 0) begin
        $display("%0t: unexpected result %h last %0b", $time, got, got_last);
        errors++;
        return;
      end
      want      = expected_entries.pop_front();
      want_last = expected_lasts.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: inverse entry expected %h actual %h", $time, want, got);
        errors++;
      end
      if (got_last !== want_last) begin
        $display("%0t: last flag expected %0b actual %0b", $time, want_last, got_last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_entries.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // signals
  // ---------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [3:0]  cfg_matrix_size;
  logic        in_valid;
  logic        in_stall;
  logic signed [31:0] in_element;
  logic        in_last_in;
  logic        out_valid;
  logic        out_stall;
  logic signed [31:0] out_inverse_element;
  logic        out_last_out;

  inverse_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned item_count;

  matrix_inverse_gauss_jordan #(.MAX_DIM(MAX_DIM)) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_matrix_size     (cfg_matrix_size),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_element          (in_element),
    .in_last_in          (in_last_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_inverse_element (out_inverse_element),
    .out_last_out        (out_last_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // timeout
  initial begin
    #40ms;
    $display("timeout with %0d entries outstanding", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stall, check on acceptance
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_inverse_element, out_last_out);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // drive one input transaction and wait for acceptance
  task automatic send_entry(q_t value, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_element <= value;
    in_last_in <= last;
    do @(posedge clk); while (in_stall);
    sb.note_input(value, last);
    item_count++;
    // the final entry closes the matrix, so valid is dropped after it
    if (last) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // wait until the block is idle, then write the size register
  task automatic write_size(logic [3:0] v);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wr_en       <= 1'b1;
    cfg_matrix_size <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_size(v);
  endtask

  // random entry: mostly moderate values, sometimes extremes
  function automatic q_t rand_entry();
    case ($urandom_range(9))
      0: return q_t'($urandom());
      1: return Q_MAX;
      2: return Q_MIN;
      3: return '0;
      default: return q_t'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  // random matrix, diagonally heavy when dominant is set so elimination stays well behaved
  task automatic send_matrix(int unsigned n, bit dominant);
    q_t v;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        v = rand_entry();
        if (dominant && r == c) v = q_t'(32'sh0004_0000 + $urandom_range(32'h0004_0000));
        send_entry(v, (r == n - 1) && (c == n - 1));
      end
    end
  endtask

  int unsigned n_cur;

  initial begin
    sb = new();
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_matrix_size = 4'd8;
    in_valid        = 1'b0;
    in_element      = '0;
    in_last_in      = 1'b0;
    out_stall       = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    item_count      = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: size 1 extremes, zero pivot, 2x2 identity, overlong load
    write_size(4'd1);
    send_entry(Q_MAX, 1'b1);
    send_entry(Q_MIN, 1'b1);
    send_entry('0, 1'b1);
    send_entry(32'sh0000_0001, 1'b1);
    send_entry(32'shFFFF_FFFF, 1'b1);
    write_size(4'd2);
    send_entry(Q_ONE, 1'b0);
    send_entry('0, 1'b0);
    send_entry('0, 1'b0);
    send_entry(Q_ONE, 1'b1);
    // zero pivot in the first column
    send_entry('0, 1'b0);
    send_entry(Q_ONE, 1'b0);
    send_entry(Q_ONE, 1'b0);
    send_entry(Q_ONE, 1'b0);
    // extra entry beyond n*n is dropped
    send_entry(32'sh5555_AAAA, 1'b0);
    send_entry(32'shAAAA_5555, 1'b1);
    // short load reuses entries written earlier
    send_entry(32'sh0002_0000, 1'b1);
    // size zero behaves as one, fifteen as the maximum
    write_size(4'd0);
    send_entry(32'sh0003_0000, 1'b1);
    write_size(4'd15);
    send_matrix(8, 1'b1);

    // random phases over idling patterns and sizes
    for (int ph = 0; item_count < 480; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      n_cur = (ph % 5 == 4) ? 8 : $urandom_range(1, 4);
      write_size(4'(n_cur));
      for (int m = 0; m < 4; m++) begin
        if ($urandom_range(9) == 0) begin
          // broken sequence: short or overlong load
          repeat ($urandom_range(1, n_cur * n_cur + 2)) send_entry(rand_entry(), 1'b0);
          send_entry(rand_entry(), 1'b1);
        end else begin
          send_matrix(n_cur, $urandom_range(3) != 0);
        end
        // hold off until every expected entry has come back
        if (m == 1)
          while (sb.pending() != 0) @(posedge clk);
      end
    end

    while (sb.pending() != 0) @(posedge clk);
    recv_stall_pct = 0;
    repeat (200) @(posedge clk);

    $display("covered %0d input entries, %0d inversions, %0d inverse entries checked",
             item_count, sb.inversions, sb.checked);
    $display("sizes 0,1,2,8,15 and random 1..4, with sender and receiver idling phases");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mig_pkg.sv
rtl/mig_div.sv
rtl/mig_msub.sv
rtl/matrix_inverse_gauss_jordan.sv
rtl/mig_checker.sv
tb/testbench.sv
